// ===== design/assert_macros.svh =====
// Assertion macros shared by the cache RTL.
// Needs a clock and an active-low reset in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define LKVC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define LKVC_IMPLY(lbl, clk, rst_n, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

`endif

// ===== design/lkvc_pkg.sv =====
// Shared types and constants for the LRU key-value cache.
// No dependencies; used by the interfaces, the cell and the top level.
`default_nettype none

package lkvc_pkg;

    localparam int DEF_MAX_ENTRIES = 16;
    localparam int KEY_W           = 32;
    localparam int VAL_W           = 32;
    localparam int CAP_W           = 5;

    localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
    localparam logic [VAL_W-1:0] MISS_VALUE = '1;
    localparam logic [VAL_W-1:0] PUT_VALUE  = '0;

    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_PUT = 1'b1;

    // Which cell an update targets
    typedef enum logic [1:0] {
        UPD_HIT,
        UPD_FILL,
        UPD_REPLACE
    } upd_mode_t;

    // Command broadcast to every cell
    typedef struct packed {
        logic             lookup;
        logic             update;
        upd_mode_t        mode;
        logic             write_key;
        logic             write_value;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } cell_cmd_t;

    // Status returned by one cell
    typedef struct packed {
        logic match;
        logic victim;
        logic valid;
    } cell_stat_t;

endpackage

`default_nettype wire

// ===== design/lkvc_if.sv =====
// Handshake interfaces for the cache: request, response and config words.
// Depends on lkvc_pkg for field widths.
`default_nettype none

interface lkvc_req_if import lkvc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    func;
    logic signed [KEY_W-1:0] lookup_key;
    logic signed [VAL_W-1:0] write_value;

    modport source (output valid, func, lookup_key, write_value, input ready);
    modport sink   (input valid, func, lookup_key, write_value, output ready);
endinterface

interface lkvc_rsp_if import lkvc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    hit;
    logic signed [VAL_W-1:0] read_value;

    modport source (output valid, hit, read_value, input ready);
    modport sink   (input valid, hit, read_value, output ready);
endinterface

interface lkvc_cfg_if import lkvc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] capacity_in_use;

    modport source (output valid, capacity_in_use, input ready);
    modport sink   (input valid, capacity_in_use, output ready);
endinterface

`default_nettype wire

// ===== design/lkvc_cell.sv =====
// One cache entry: key, value, valid bit and recency rank, with its own
// key compare and rank aging. Depends on lkvc_pkg.
`default_nettype none

module lkvc_cell import lkvc_pkg::*; #(
    parameter  int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter  int IDX         = 0,
    localparam int SLOT_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cell_cmd_t         cmd,
    input  wire logic [SLOT_W-1:0] victim_rank,
    input  wire logic [SLOT_W:0]   old_rank,
    input  wire logic [SLOT_W-1:0] fill_slot,
    output cell_stat_t             stat,
    output logic [VAL_W-1:0]       sel_value,
    output logic [SLOT_W-1:0]      sel_rank
);

    logic              valid_reg;
    logic [SLOT_W-1:0] rank_reg;
    logic              match_reg;
    logic              victim_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [VAL_W-1:0]  value_reg;
    logic              target;
    logic              ages;

    // Pick whether this cell is the one being written
    always_comb
    begin
        unique case (cmd.mode)
            UPD_HIT:     target = match_reg;
            UPD_FILL:    target = (fill_slot == SLOT_W'(IDX));
            UPD_REPLACE: target = victim_reg;
            default:     target = 1'b0;
        endcase
    end

    // Entries more recent than the touched one age by one
    assign ages = valid_reg && ({1'b0, rank_reg} < old_rank);

    // Hold valid, rank and compare flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            rank_reg   <= '0;
            match_reg  <= 1'b0;
            victim_reg <= 1'b0;
        end
        else
        begin
            if (cmd.lookup)
            begin
                match_reg  <= valid_reg && (key_reg == cmd.key);
                victim_reg <= valid_reg && (rank_reg == victim_rank);
            end
            if (cmd.update)
            begin
                if (target)
                begin
                    valid_reg <= 1'b1;
                    rank_reg  <= '0;
                end
                else if (ages)
                begin
                    rank_reg <= rank_reg + SLOT_W'(1);
                end
            end
        end
    end

    // Store key and value words
    always_ff @(posedge clk)
    begin
        if (cmd.update && target && cmd.write_key)
        begin
            key_reg <= cmd.key;
        end
        if (cmd.update && target && cmd.write_value)
        begin
            value_reg <= cmd.value;
        end
    end

    assign stat.match  = match_reg;
    assign stat.victim = victim_reg;
    assign stat.valid  = valid_reg;
    assign sel_value   = match_reg ? value_reg : '0;
    assign sel_rank    = match_reg ? rank_reg : '0;

endmodule

`default_nettype wire

// ===== design/lru_key_value_cache.sv =====
// Top level of the LRU key-value cache: a row of entry cells and the control.
// Depends on lkvc_pkg, lkvc_if, lkvc_cell and assert_macros.svh.
//
// Fully associative get/put cache of MAX_ENTRIES entries with least-recently-
// used replacement. One request word is taken at a time and answered by one
// response word. The accepting edge captures the request. In the next cycle
// every cell compares its key and rank in parallel and registers the result.
// In the update state the cell results are merged, ranks, key and value are
// updated and the response register loads. The next request is accepted in
// the cycle after the update. The update waits while an earlier response
// still sits unaccepted in its register; no new request is accepted
// meanwhile. No clearing pass is needed after reset. The capacity
// register is always ready; write it only while the cache is idle.
`default_nettype none
`include "assert_macros.svh"

module lru_key_value_cache import lkvc_pkg::*; #(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
    input  wire logic clk,
    input  wire logic rst_n,
    lkvc_req_if.sink   req,
    lkvc_rsp_if.source rsp,
    lkvc_cfg_if.sink   cfg
);

    localparam int SLOT_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_UPD
    } state_t;

    state_t            state_reg,     state_next;
    logic [CAP_W-1:0]  cap_reg,       cap_next;
    logic [CNT_W-1:0]  occ_reg,       occ_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_hit_reg,   out_hit_next;
    logic [VAL_W-1:0]  out_value_reg, out_value_next;
    logic              func_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [VAL_W-1:0]  val_reg;

    cell_cmd_t         cmd;
    cell_stat_t        stat       [MAX_ENTRIES];
    logic [VAL_W-1:0]  sel_value  [MAX_ENTRIES];
    logic [SLOT_W-1:0] sel_rank   [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] match_vec;
    logic [MAX_ENTRIES-1:0] victim_vec;
    logic [MAX_ENTRIES-1:0] valid_vec;

    logic              accept;
    logic              upd_fire;
    logic              hit_now;
    logic              is_put;
    logic              do_fill;
    logic              do_replace;
    logic [VAL_W-1:0]  hit_value;
    logic [SLOT_W-1:0] hit_rank;
    logic [SLOT_W-1:0] victim_rank;
    logic [SLOT_W:0]   old_rank;
    logic [SLOT_W-1:0] fill_slot;
    logic [CMP_W-1:0]  occ_ext;
    logic [CMP_W-1:0]  cap_ext;

    // Row of entry cells
    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        lkvc_cell #(
            .MAX_ENTRIES (MAX_ENTRIES),
            .IDX         (i)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .victim_rank (victim_rank),
            .old_rank    (old_rank),
            .fill_slot   (fill_slot),
            .stat        (stat[i]),
            .sel_value   (sel_value[i]),
            .sel_rank    (sel_rank[i])
        );
        assign match_vec[i]  = stat[i].match;
        assign victim_vec[i] = stat[i].victim;
        assign valid_vec[i]  = stat[i].valid;
    end

    // Merge the one matching cell's value and rank
    always_comb
    begin
        hit_value = '0;
        hit_rank  = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            hit_value = hit_value | sel_value[i];
            hit_rank  = hit_rank | sel_rank[i];
        end
    end

    assign hit_now = |match_vec;
    assign is_put  = (func_reg == FUNC_PUT);

    // Decide between filling a free slot and replacing the oldest entry
    assign occ_ext     = CMP_W'(occ_reg);
    assign cap_ext     = (cap_reg == '0) ? CMP_W'(1) : CMP_W'(cap_reg);
    assign do_fill     = !hit_now && is_put && (occ_ext < cap_ext)
                         && (occ_reg != CNT_W'(MAX_ENTRIES));
    assign do_replace  = (state_reg == ST_UPD) && !hit_now && is_put && !do_fill;
    assign victim_rank = SLOT_W'(occ_reg - CNT_W'(1));
    assign fill_slot   = SLOT_W'(occ_reg);

    assign accept   = req.valid && req.ready;
    assign upd_fire = (state_reg == ST_UPD) && (!out_valid_reg || rsp.ready);

    // Build the cell command
    always_comb
    begin
        cmd.lookup      = (state_reg == ST_LOOK);
        cmd.update      = upd_fire && (hit_now || is_put);
        cmd.write_key   = !hit_now;
        cmd.write_value = is_put;
        cmd.key         = key_reg;
        cmd.value       = val_reg;
        if (hit_now)
        begin
            cmd.mode = UPD_HIT;
            old_rank = {1'b0, hit_rank};
        end
        else if (do_fill)
        begin
            cmd.mode = UPD_FILL;
            old_rank = (SLOT_W + 1)'(MAX_ENTRIES);
        end
        else
        begin
            cmd.mode = UPD_REPLACE;
            old_rank = {1'b0, victim_rank};
        end
    end

    // Next state, occupancy, capacity and response register
    always_comb
    begin
        state_next     = state_reg;
        cap_next       = cap_reg;
        occ_next       = occ_reg;
        out_valid_next = out_valid_reg;
        out_hit_next   = out_hit_reg;
        out_value_next = out_value_reg;

        if (cfg.valid && cfg.ready)
        begin
            cap_next = cfg.capacity_in_use;
        end

        if (rsp.valid && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (upd_fire)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    out_hit_next   = hit_now;
                    if (is_put)
                    begin
                        out_value_next = PUT_VALUE;
                    end
                    else if (hit_now)
                    begin
                        out_value_next = hit_value;
                    end
                    else
                    begin
                        out_value_next = MISS_VALUE;
                    end
                    if (do_fill)
                    begin
                        occ_next = occ_reg + CNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cap_reg       <= CAP_RESET;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_hit_reg   <= 1'b0;
            out_value_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cap_reg       <= cap_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
            out_hit_reg   <= out_hit_next;
            out_value_reg <= out_value_next;
        end
    end

    // Capture the request word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= req.func;
            key_reg  <= req.lookup_key;
            val_reg  <= req.write_value;
        end
    end

    assign req.ready      = (state_reg == ST_IDLE);
    assign cfg.ready      = 1'b1;
    assign rsp.valid      = out_valid_reg;
    assign rsp.hit        = out_hit_reg;
    assign rsp.read_value = out_value_reg;

    `LKVC_ASSERT(a_single_match, clk, rst_n, $onehot0(match_vec), "more than one cell matched")
    `LKVC_ASSERT(a_valid_count, clk, rst_n, $countones(valid_vec) == occ_reg, "occupancy mismatch")
    `LKVC_ASSERT(a_occ_bound, clk, rst_n, occ_reg <= CNT_W'(MAX_ENTRIES), "occupancy too high")
    `LKVC_IMPLY(a_victim_unique, clk, rst_n, do_replace, $onehot(victim_vec), "no unique victim")

endmodule

`default_nettype wire

// ===== dv/lru_key_value_cache_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for lru_key_value_cache: directed and random get/put words.
// Depends on lkvc_pkg and the lkvc_*_if interfaces; predicts every response in-line.

module lru_key_value_cache_tb;
    import lkvc_pkg::*;

    localparam int NUM_SLOTS   = DEF_MAX_ENTRIES;
    localparam int POOL_SIZE   = 48;
    localparam int PHASE_WORDS = 160;
    localparam int TAIL_CYCLES = 12;
    localparam int CYCLE_LIMIT = 400_000;
    localparam int REPORT_MAX  = 10;

    typedef enum logic [1:0] {
        STEP_WORD,
        STEP_CAP,
        STEP_DRAIN
    } step_kind_t;

    typedef struct {
        step_kind_t       kind;
        logic             func;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic [CAP_W-1:0] cap;
    } step_t;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] read_value;
    } answer_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    lkvc_req_if req ();
    lkvc_rsp_if rsp ();
    lkvc_cfg_if cfg ();

    lru_key_value_cache dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    // Free-running clock, 2 ns period
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Shadow copy of the cache contents
    logic [KEY_W-1:0] slot_key   [NUM_SLOTS];
    logic [VAL_W-1:0] slot_value [NUM_SLOTS];
    bit               slot_valid [NUM_SLOTS];
    int unsigned      slot_rank  [NUM_SLOTS];
    int unsigned      fill_count;
    logic [CAP_W-1:0] cap_reg;

    step_t            request_q[$];
    answer_t          answer_q[$];
    logic [KEY_W-1:0] key_pool[POOL_SIZE];

    int sent_count;
    int answered_count;
    int error_count;
    int cycle_count;
    int gap_left;
    int burst_left;
    int get_total;
    int put_total;
    int hit_total;
    int evict_total;
    int cap_writes;

    // Record one failure; print only the first few
    task automatic note_failure(input string what);
        error_count++;
        if (error_count <= REPORT_MAX)
            $display("ERROR @%0t: %s", $time, what);
    endtask

    // Make a slot most recent: valid entries younger than old_rank age by one
    function automatic void promote(input int s, input int unsigned old_rank);
        for (int i = 0; i < NUM_SLOTS; i++)
            if (slot_valid[i] && i != s && slot_rank[i] < old_rank)
                slot_rank[i]++;
        slot_rank[s] = 0;
    endfunction

    // Apply one get/put to the shadow cache and return the response it must give
    function automatic answer_t lru_access(input logic op, input logic [KEY_W-1:0] key,
                                           input logic [VAL_W-1:0] value);
        int unsigned eff_cap;
        int unsigned oldest;
        int          hit_slot;
        int          free_slot;
        int          lru_slot;
        answer_t     ans;
        eff_cap   = (cap_reg == 0) ? 1 : (cap_reg > NUM_SLOTS) ? NUM_SLOTS : cap_reg;
        hit_slot  = -1;
        free_slot = -1;
        lru_slot  = -1;
        oldest    = 0;
        if (op == FUNC_GET)
            get_total++;
        else
            put_total++;

        // Search for the key, the oldest entry and the lowest free slot
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (slot_valid[i])
            begin
                if (hit_slot < 0 && slot_key[i] == key)
                    hit_slot = i;
                if (lru_slot < 0 || slot_rank[i] > oldest)
                begin
                    lru_slot = i;
                    oldest   = slot_rank[i];
                end
            end
            else if (free_slot < 0)
                free_slot = i;
        end

        if (hit_slot >= 0)
        begin
            hit_total++;
            ans.hit = 1'b1;
            if (op == FUNC_GET)
                ans.read_value = slot_value[hit_slot];
            else
            begin
                slot_value[hit_slot] = value;
                ans.read_value = PUT_VALUE;
            end
            promote(hit_slot, slot_rank[hit_slot]);
            return ans;
        end

        ans.hit = 1'b0;
        if (op == FUNC_GET)
        begin
            ans.read_value = MISS_VALUE;
            return ans;
        end
        ans.read_value = PUT_VALUE;

        // Fill a free slot below capacity, otherwise replace the oldest entry
        if (fill_count < eff_cap && free_slot >= 0)
        begin
            slot_valid[free_slot] = 1'b1;
            slot_key[free_slot]   = key;
            slot_value[free_slot] = value;
            promote(free_slot, NUM_SLOTS);
            fill_count++;
        end
        else if (lru_slot >= 0)
        begin
            evict_total++;
            slot_key[lru_slot]   = key;
            slot_value[lru_slot] = value;
            promote(lru_slot, slot_rank[lru_slot]);
        end
        return ans;
    endfunction

    function automatic void queue_word(input logic op, input logic [KEY_W-1:0] key,
                                       input logic [VAL_W-1:0] value);
        step_t s;
        s.kind  = STEP_WORD;
        s.func  = op;
        s.key   = key;
        s.value = value;
        s.cap   = '0;
        request_q.push_back(s);
    endfunction

    function automatic void queue_capacity(input logic [CAP_W-1:0] c);
        step_t s;
        s.kind  = STEP_CAP;
        s.func  = FUNC_GET;
        s.key   = '0;
        s.value = '0;
        s.cap   = c;
        request_q.push_back(s);
        cap_writes++;
    endfunction

    function automatic void queue_drain();
        step_t s;
        s.kind  = STEP_DRAIN;
        s.func  = FUNC_GET;
        s.key   = '0;
        s.value = '0;
        s.cap   = '0;
        request_q.push_back(s);
    endfunction

    // Request driver: feed words in bursts, write capacity only when idle
    always @(posedge clk or negedge rst_n)
    begin : request_driver
        answer_t ans;
        step_t   nxt;
        bit      word_taken;
        bit      cap_taken;
        bit      next_req_valid;
        bit      next_cfg_valid;
        int      in_flight;
        if (!rst_n)
        begin
            req.valid           <= 1'b0;
            req.func            <= FUNC_GET;
            req.lookup_key      <= '0;
            req.write_value     <= '0;
            cfg.valid           <= 1'b0;
            cfg.capacity_in_use <= CAP_RESET;
            sent_count          <= 0;
            gap_left   = 0;
            burst_left = 1;
            fill_count = 0;
            cap_reg    = CAP_RESET;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                slot_valid[i] = 1'b0;
                slot_rank[i]  = 0;
                slot_key[i]   = '0;
                slot_value[i] = '0;
            end
        end
        else
        begin
            word_taken = req.valid && req.ready;
            cap_taken  = cfg.valid && cfg.ready;

            // Predict the response for the word accepted at this edge
            if (word_taken)
            begin
                ans = lru_access(req.func, req.lookup_key, req.write_value);
                answer_q.push_back(ans);
                sent_count <= sent_count + 1;
            end
            if (cap_taken)
                cap_reg = cfg.capacity_in_use;

            in_flight      = sent_count + int'(word_taken) - answered_count;
            next_req_valid = req.valid && !word_taken;
            next_cfg_valid = cfg.valid && !cap_taken;

            // Advance to the next step once nothing is held
            if (!next_req_valid && !next_cfg_valid && request_q.size() > 0)
            begin
                case (request_q[0].kind)
                    STEP_WORD:
                    begin
                        if (gap_left > 0)
                            gap_left--;
                        else
                        begin
                            nxt = request_q.pop_front();
                            req.func        <= nxt.func;
                            req.lookup_key  <= nxt.key;
                            req.write_value <= nxt.value;
                            next_req_valid = 1'b1;
                            burst_left--;
                            if (burst_left <= 0)
                            begin
                                burst_left = $urandom_range(1, 24);
                                gap_left   = ($urandom_range(0, 3) == 0) ? 0
                                                                         : $urandom_range(1, 6);
                            end
                        end
                    end
                    STEP_CAP:
                    begin
                        if (in_flight == 0)
                        begin
                            nxt = request_q.pop_front();
                            cfg.capacity_in_use <= nxt.cap;
                            next_cfg_valid = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (in_flight == 0)
                            nxt = request_q.pop_front();
                    end
                endcase
            end

            req.valid <= next_req_valid;
            cfg.valid <= next_cfg_valid;
        end
    end

    // Response monitor: stall on a changing pattern, check each word in order
    always @(posedge clk or negedge rst_n)
    begin : response_monitor
        answer_t     want;
        int unsigned stall_mode;
        int unsigned mode_left;
        int unsigned stall_period;
        if (!rst_n)
        begin
            rsp.ready      <= 1'b0;
            answered_count <= 0;
            mode_left    = 0;
            stall_mode   = 0;
            stall_period = 2;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                answered_count <= answered_count + 1;
                if (answer_q.size() == 0)
                    note_failure($sformatf("unexpected response hit=%0b read_value=%h",
                                           rsp.hit, rsp.read_value));
                else
                begin
                    want = answer_q.pop_front();
                    if (rsp.hit !== want.hit)
                        note_failure($sformatf("hit: expected %0b, got %0b",
                                               want.hit, rsp.hit));
                    if (rsp.read_value !== want.read_value)
                        note_failure($sformatf("read_value: expected %h, got %h",
                                               want.read_value, rsp.read_value));
                end
            end

            // Pick a new stall pattern now and then
            if (mode_left == 0)
            begin
                stall_mode   = $urandom_range(0, 2);
                mode_left    = $urandom_range(20, 120);
                stall_period = $urandom_range(2, 7);
            end
            mode_left--;
            case (stall_mode)
                0:       rsp.ready <= 1'b1;
                1:       rsp.ready <= 1'($urandom_range(0, 1));
                default: rsp.ready <= (mode_left % stall_period == 0);
            endcase
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Stimulus, reset and end of run
    initial
    begin : stimulus
        logic [CAP_W-1:0] phase_caps[10];
        int unsigned      eff_cap;
        int unsigned      span;
        logic [KEY_W-1:0] key;
        logic             op;

        // Known values on every input before the first edge
        req.valid           = 1'b0;
        req.func            = FUNC_GET;
        req.lookup_key      = '0;
        req.write_value     = '0;
        rsp.ready           = 1'b0;
        cfg.valid           = 1'b0;
        cfg.capacity_in_use = CAP_RESET;

        // Key pool with the signed extremes at the front
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;

        // Directed: empty miss, extremes, overwrite, ignored value on a get
        queue_word(FUNC_GET, 32'h0000_0000, 32'h0000_0000);
        queue_word(FUNC_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_word(FUNC_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_word(FUNC_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
        queue_word(FUNC_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
        queue_word(FUNC_GET, 32'h8000_0000, 32'h0000_0000);
        queue_word(FUNC_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        queue_word(FUNC_GET, 32'h0000_0000, 32'h0000_0000);
        queue_word(FUNC_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        queue_word(FUNC_PUT, 32'h8000_0000, 32'h1234_5678);
        queue_word(FUNC_GET, 32'h8000_0000, 32'h0000_0000);
        queue_word(FUNC_GET, 32'h5555_5555, 32'h0000_0000);
        queue_word(FUNC_GET, 32'h7FFF_FFFF, 32'hAAAA_AAAA);
        // Capacity dropped below occupancy: puts replace the oldest entry
        queue_capacity(5'd1);
        queue_word(FUNC_PUT, 32'h0000_00A5, 32'h0000_0001);
        queue_word(FUNC_GET, 32'h0000_0000, 32'h0000_0000);
        queue_word(FUNC_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        queue_word(FUNC_PUT, 32'h0000_005A, 32'h0000_0002);
        // Capacity zero behaves as one
        queue_capacity(5'd0);
        queue_word(FUNC_PUT, 32'h1111_1111, 32'h0000_0003);
        queue_word(FUNC_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        queue_word(FUNC_GET, 32'h0000_005A, 32'h0000_0000);
        // Capacity above the entry count behaves as full size
        queue_capacity(5'd31);
        queue_word(FUNC_PUT, 32'h2222_2222, 32'h0000_0004);
        queue_word(FUNC_GET, 32'h2222_2222, 32'h0000_0000);

        // Random phases, each at its own capacity, keys mostly from a small pool
        phase_caps = '{5'd2, 5'd31, 5'd5, 5'd0, 5'd16, 5'd9, 5'd1, 5'd17, 5'd12, 5'd0};
        phase_caps[9] = 5'($urandom_range(0, 31));
        foreach (phase_caps[p])
        begin
            queue_capacity(phase_caps[p]);
            eff_cap = (phase_caps[p] == 0) ? 1
                    : (phase_caps[p] > NUM_SLOTS) ? NUM_SLOTS : phase_caps[p];
            span = eff_cap + $urandom_range(0, 6);
            if (span > POOL_SIZE)
                span = POOL_SIZE;
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                if ($urandom_range(0, 99) == 0)
                    queue_drain();
                op  = 1'($urandom_range(0, 1));
                key = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, span - 1)]
                                                 : 32'($urandom);
                queue_word(op, key, 32'($urandom));
            end
        end

        // Reset once
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every word to be answered, then a short tail
        while (request_q.size() != 0 || req.valid || cfg.valid ||
               sent_count != answered_count)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (answer_q.size() != 0)
            note_failure($sformatf("%0d responses never arrived", answer_q.size()));
        if (error_count > REPORT_MAX)
            $display("%0d further errors not shown", error_count - REPORT_MAX);

        $display("Ran %0d words (%0d gets, %0d puts) across %0d capacity writes.",
                 sent_count, get_total, put_total, cap_writes);
        $display("Saw %0d hits and %0d evictions; %0d errors.",
                 hit_total, evict_total, error_count);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
